@@ rtl/core/ehdc_pkg.sv @@
// Shared types, constants and small lookup functions for the date classifier.
// Used by every file under rtl/core except ehdc_if.sv; depends on nothing else.

package ehdc_pkg;

	// Reciprocal constants for division by fixed divisors (multiply, then shift).
	localparam logic [15:0] RECIP_100 = 16'd5243;
	localparam int unsigned SH_100    = 19;
	localparam logic [15:0] RECIP_19  = 16'd27595;
	localparam int unsigned SH_19     = 19;
	localparam logic [15:0] RECIP_7   = 16'd37450;
	localparam int unsigned SH_7      = 18;
	localparam logic [15:0] RECIP_25  = 16'd1311;
	localparam int unsigned SH_25     = 15;

	// Holiday codes.
	localparam logic [2:0] HOL_NONE       = 3'd0;
	localparam logic [2:0] HOL_EASTER     = 3'd1;
	localparam logic [2:0] HOL_GOOD_FRI   = 3'd2;
	localparam logic [2:0] HOL_ASCENSION  = 3'd3;
	localparam logic [2:0] HOL_WHIT_MON   = 3'd4;
	localparam logic [2:0] HOL_EASTER_MON = 3'd5;
	localparam logic [2:0] HOL_FIXED      = 3'd6;

	// Bit M set when (11*M + 11) mod 30 < 19, for epact M in 0..29.
	localparam logic [29:0] EPACT_LOW_MASK = 30'b10101_10110_10110_11011_01011_01101;

	// Year decomposition handed from the front stages to the back stages.
	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  mon;
		logic [13:0] year;
		logic [7:0]  cent;   // year / 100
		logic [4:0]  gold;   // year mod 19
		logic [2:0]  rem7;   // year mod 7
		logic [15:0] wsum;   // weekday sum before reduction mod 7
	} split_t;

	// Remainder mod 7 by reciprocal; exact for x below 43690.
	function automatic logic [2:0] mod7(input logic [15:0] x);
		logic [31:0] prod;
		logic [15:0] quo;
		logic [15:0] rem;
		prod = 32'(x) * 32'(RECIP_7);
		quo  = 16'(prod >> SH_7);
		rem  = x - quo * 16'd7;
		return rem[2:0];
	endfunction

	// Remainder mod 7 by compare and subtract; exact for x below 35.
	function automatic logic [2:0] mod7_small(input logic [5:0] x);
		logic [5:0] r;
		if (x >= 6'd28) begin
			r = x - 6'd28;
		end else if (x >= 6'd21) begin
			r = x - 6'd21;
		end else if (x >= 6'd14) begin
			r = x - 6'd14;
		end else if (x >= 6'd7) begin
			r = x - 6'd7;
		end else begin
			r = x;
		end
		return r[2:0];
	endfunction

	// (19 * a) mod 30 for a in 0..18.
	function automatic logic [4:0] gold19(input logic [4:0] a);
		logic [4:0] r;
		case (a)
			5'd0:    r = 5'd0;
			5'd1:    r = 5'd19;
			5'd2:    r = 5'd8;
			5'd3:    r = 5'd27;
			5'd4:    r = 5'd16;
			5'd5:    r = 5'd5;
			5'd6:    r = 5'd24;
			5'd7:    r = 5'd13;
			5'd8:    r = 5'd2;
			5'd9:    r = 5'd21;
			5'd10:   r = 5'd10;
			5'd11:   r = 5'd29;
			5'd12:   r = 5'd18;
			5'd13:   r = 5'd7;
			5'd14:   r = 5'd26;
			5'd15:   r = 5'd15;
			5'd16:   r = 5'd4;
			5'd17:   r = 5'd23;
			5'd18:   r = 5'd12;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Month term of the weekday sum: (31 * shifted month) / 12.
	function automatic logic [5:0] month_term(input logic [3:0] m);
		logic [5:0] r;
		case (m)
			4'd0:    r = 6'd25;
			4'd1:    r = 6'd28;
			4'd2:    r = 6'd31;
			4'd3:    r = 6'd2;
			4'd4:    r = 6'd5;
			4'd5:    r = 6'd7;
			4'd6:    r = 6'd10;
			4'd7:    r = 6'd12;
			4'd8:    r = 6'd15;
			4'd9:    r = 6'd18;
			4'd10:   r = 6'd20;
			4'd11:   r = 6'd23;
			4'd12:   r = 6'd25;
			4'd13:   r = 6'd28;
			4'd14:   r = 6'd31;
			default: r = 6'd33;
		endcase
		return r;
	endfunction

	// Days in the month; zero for a month number outside 1..12.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
			4'd2:    r = leap ? 5'd29 : 5'd28;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Day index of day 0 of March..June, March 1 counting as 1.
	function automatic logic [6:0] spring_base(input logic [3:0] m);
		logic [6:0] r;
		case (m)
			4'd4:    r = 7'd31;
			4'd5:    r = 7'd61;
			4'd6:    r = 7'd92;
			default: r = 7'd0;
		endcase
		return r;
	endfunction

	// Fixed public holidays.
	function automatic logic fixed_holiday(input logic [3:0] m, input logic [4:0] d);
		return (m == 4'd1  && d == 5'd1)  || (m == 4'd3  && d == 5'd1)  ||
		       (m == 4'd3  && d == 5'd8)  || (m == 4'd7  && d == 5'd14) ||
		       (m == 4'd8  && d == 5'd15) || (m == 4'd11 && d == 5'd1)  ||
		       (m == 4'd11 && d == 5'd11) || (m == 4'd12 && d == 5'd25) ||
		       (m == 4'd12 && d == 5'd26);
	endfunction

endpackage

@@ rtl/core/ehdc_if.sv @@
// Channel interfaces of the date classifier: date input and classification result.
// Depends on nothing; widths follow the field list of the block.

interface ehdc_date_if;
	logic        valid;
	logic        ready;
	logic [4:0]  day_of_month;
	logic [3:0]  month_number;
	logic [13:0] year_number;

	modport source (output valid, output day_of_month, output month_number,
		output year_number, input ready);
	modport sink (input valid, input day_of_month, input month_number,
		input year_number, output ready);
endinterface

interface ehdc_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] weekday;
	logic       weekend;
	logic       leap_year;
	logic [4:0] month_length;
	logic [2:0] easter_month;
	logic [4:0] easter_day;
	logic [2:0] holiday_code;

	modport source (output valid, output weekday, output weekend, output leap_year,
		output month_length, output easter_month, output easter_day,
		output holiday_code, input ready);
	modport sink (input valid, input weekday, input weekend, input leap_year,
		input month_length, input easter_month, input easter_day,
		input holiday_code, output ready);
endinterface

@@ rtl/core/easter_holiday_date_classifier.sv @@
// Top level of the Gregorian date classifier with Easter-based holidays.
// Depends on ehdc_pkg, ehdc_if, ehdc_year_split and ehdc_easter_core.
//
// Usage:
//   dates   - sink channel; one transaction carries day_of_month, month_number
//             and year_number of one Gregorian date.
//   results - source channel; one transaction per date with weekday, weekend,
//             leap_year, month_length, easter_month, easter_day, holiday_code.
//   A transaction completes at a rising edge of clk with valid and ready high.
//
// A taken date moves through the input register, year decomposition, epact stage
// and result register, in that order, before its result is offered.
// Throughput: one date per cycle while results are taken, set by the four-stage
// register pipeline; each stage advances when the next has room, so a date is
// taken while a finished result still waits at the output and a stage is free.
// Stall: when results.ready is low the pipeline fills up; dates.ready drops
// only once all four stages hold a transaction. Nothing is lost or repeated.
// Reset: arst_n clears all stage valid bits; stage data registers are not reset.

module easter_holiday_date_classifier (
	input  logic          clk,
	input  logic          arst_n,
	ehdc_date_if.sink     dates,
	ehdc_result_if.source results
);

	ehdc_pkg::split_t split;
	logic             split_valid;
	logic             split_ready;

	ehdc_year_split u_split (
		.clk         (clk),
		.arst_n      (arst_n),
		.dates       (dates),
		.split       (split),
		.split_valid (split_valid),
		.split_ready (split_ready)
	);

	ehdc_easter_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.split       (split),
		.split_valid (split_valid),
		.split_ready (split_ready),
		.results     (results)
	);

endmodule

@@ rtl/core/ehdc_year_split.sv @@
// Front half of the classifier: input register and year decomposition stage.
// Depends on ehdc_pkg and ehdc_date_if.

module ehdc_year_split (
	input  logic            clk,
	input  logic            arst_n,
	ehdc_date_if.sink       dates,
	output ehdc_pkg::split_t split,
	output logic            split_valid,
	input  logic            split_ready
);

	logic             v_s1;
	logic             v_s2;
	logic [4:0]       day_s1;
	logic [3:0]       mon_s1;
	logic [13:0]      year_s1;
	ehdc_pkg::split_t split_s2;
	ehdc_pkg::split_t split_d;
	logic             load_s1;
	logic             load_s2;

	logic        early;
	logic [15:0] yy;
	logic [31:0] prod_cy;
	logic [31:0] prod_c;
	logic [31:0] prod_g;
	logic [7:0]  cent_yy;
	logic [9:0]  gq;

	// Advance a stage when it is empty or its content moves on.
	assign load_s2     = !v_s2 || split_ready;
	assign load_s1     = !v_s1 || load_s2;
	assign dates.ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= dates.valid;
			end
			if (load_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Capture the date transaction.
	always_ff @(posedge clk) begin
		if (load_s1 && dates.valid) begin
			day_s1  <= dates.day_of_month;
			mon_s1  <= dates.month_number;
			year_s1 <= dates.year_number;
		end
	end

	// Split the year: centuries, golden number, mod 7, and the weekday sum.
	always_comb begin
		early   = (mon_s1 <= 4'd2);
		yy      = 16'(year_s1) + 16'd400 - 16'(early);
		prod_cy = 32'(yy) * 32'(ehdc_pkg::RECIP_100);
		cent_yy = 8'(prod_cy >> ehdc_pkg::SH_100);
		prod_c  = 32'(year_s1) * 32'(ehdc_pkg::RECIP_100);
		prod_g  = 32'(year_s1) * 32'(ehdc_pkg::RECIP_19);
		gq      = 10'(prod_g >> ehdc_pkg::SH_19);

		split_d.day  = day_s1;
		split_d.mon  = mon_s1;
		split_d.year = year_s1;
		split_d.cent = 8'(prod_c >> ehdc_pkg::SH_100);
		split_d.gold = 5'(year_s1 - 14'(gq) * 14'd19);
		split_d.rem7 = ehdc_pkg::mod7(16'(year_s1));
		split_d.wsum = 16'(day_s1) + yy + (yy >> 2) - 16'(cent_yy) + 16'(cent_yy >> 2)
			+ 16'(ehdc_pkg::month_term(mon_s1));
	end

	always_ff @(posedge clk) begin
		if (load_s2 && v_s1) begin
			split_s2 <= split_d;
		end
	end

	assign split       = split_s2;
	assign split_valid = v_s2;

	// Decomposed remainders stay in range.
	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (split_s2.gold < 5'd19) && (split_s2.rem7 < 3'd7) && (split_s2.cent <= 8'd163))
		else $error("year decomposition out of range");

	// A stalled pipeline keeps both stages and the handed-over content.
	a_split_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && !split_ready) |=> (v_s1 && v_s2 && $stable(split_s2)))
		else $error("front stage lost content under stall");

	// The input side stays closed only while both stages are full.
	a_split_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!dates.ready |-> (v_s1 && v_s2 && !split_ready))
		else $error("input refused with room in the front stages");

endmodule

@@ rtl/core/ehdc_easter_core.sv @@
// Back half of the classifier: Gauss epact stage and the result register.
// Depends on ehdc_pkg and ehdc_result_if.

module ehdc_easter_core (
	input  logic             clk,
	input  logic             arst_n,
	input  ehdc_pkg::split_t split,
	input  logic             split_valid,
	output logic             split_ready,
	ehdc_result_if.source    results
);

	logic       v_s3;
	logic       v_s4;
	logic       load_s3;
	logic       load_s4;

	logic [4:0] day_s3;
	logic [3:0] mon_s3;
	logic       leap_s3;
	logic [4:0] epact_s3;
	logic [2:0] nfix_s3;
	logic [2:0] kbc_s3;
	logic [4:0] gold_s3;
	logic [2:0] wd_s3;

	// Stage 3 logic.
	logic [7:0]  pq;
	logic [10:0] qx;
	logic [31:0] prod_q;
	logic [5:0]  qv;
	logic [7:0]  mraw;
	logic [4:0]  m30;
	logic [13:0] rem100;
	logic        z100;
	logic        leap_d;

	// Stage 4 logic.
	logic [5:0] dsum;
	logic [4:0] dd;
	logic [2:0] dr;
	logic [2:0] negd;
	logic [2:0] ee;
	logic [5:0] ei;
	logic [6:0] qi;
	logic [6:0] ei7;
	logic [4:0] len;
	logic       in_range;
	logic       spring;
	logic [2:0] hol;
	logic [2:0] wd_d;

	assign load_s4     = !v_s4 || results.ready;
	assign load_s3     = !v_s3 || load_s4;
	assign split_ready = load_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (load_s3) begin
				v_s3 <= split_valid;
			end
			if (load_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Epact M, offset N, partial weekday term of Easter, leap flag, weekday.
	always_comb begin
		pq     = split.cent - (split.cent >> 2);
		qx     = 11'd13 + {split.cent, 3'b000};
		prod_q = 32'(qx) * 32'(ehdc_pkg::RECIP_25);
		qv     = 6'(prod_q >> ehdc_pkg::SH_25);
		mraw   = 8'd15 + pq - 8'(qv);
		if (mraw >= 8'd60) begin
			m30 = 5'(mraw - 8'd60);
		end else if (mraw >= 8'd30) begin
			m30 = 5'(mraw - 8'd30);
		end else begin
			m30 = 5'(mraw);
		end
		rem100 = split.year - 14'(split.cent) * 14'd100;
		z100   = (rem100 == 14'd0);
		leap_d = ((split.year[1:0] == 2'd0) && !z100) || (z100 && (split.cent[1:0] == 2'd0));
	end

	always_ff @(posedge clk) begin
		if (load_s3 && split_valid) begin
			day_s3   <= split.day;
			mon_s3   <= split.mon;
			leap_s3  <= leap_d;
			epact_s3 <= m30;
			nfix_s3  <= ehdc_pkg::mod7(16'(8'd4 + pq));
			kbc_s3   <= ehdc_pkg::mod7(16'({split.year[1:0], 1'b0}) + 16'({split.rem7, 2'b00}));
			gold_s3  <= split.gold;
			wd_s3    <= ehdc_pkg::mod7(split.wsum);
		end
	end

	// Easter Sunday as a day index from March 1, then the holiday search.
	always_comb begin
		dsum = 6'(ehdc_pkg::gold19(gold_s3)) + 6'(epact_s3);
		dd   = (dsum >= 6'd30) ? 5'(dsum - 6'd30) : 5'(dsum);
		dr   = ehdc_pkg::mod7_small(6'(dd));
		negd = (dr == 3'd0) ? 3'd0 : 3'd7 - dr;
		ee   = ehdc_pkg::mod7_small(6'(kbc_s3) + 6'(nfix_s3) + 6'(negd));

		// Gauss corner cases: late epact pushes Easter back one week.
		if (dd == 5'd29 && ee == 3'd6) begin
			ei = 6'd50;
		end else if (dd == 5'd28 && ee == 3'd6 && ehdc_pkg::EPACT_LOW_MASK[epact_s3]) begin
			ei = 6'd49;
		end else begin
			ei = 6'd22 + 6'(dd) + 6'(ee);
		end

		len      = ehdc_pkg::month_days(mon_s3, leap_s3);
		in_range = (len != 5'd0) && (day_s3 != 5'd0) && (day_s3 <= len);
		spring   = (mon_s3 >= 4'd3) && (mon_s3 <= 4'd6);
		qi       = ehdc_pkg::spring_base(mon_s3) + 7'(day_s3);
		ei7      = 7'(ei);

		hol = ehdc_pkg::HOL_NONE;
		if (in_range) begin
			if (spring) begin
				if (qi == ei7) begin
					hol = ehdc_pkg::HOL_EASTER;
				end else if (qi + 7'd2 == ei7) begin
					hol = ehdc_pkg::HOL_GOOD_FRI;
				end else if (qi == ei7 + 7'd39) begin
					hol = ehdc_pkg::HOL_ASCENSION;
				end else if (qi == ei7 + 7'd50) begin
					hol = ehdc_pkg::HOL_WHIT_MON;
				end else if (qi == ei7 + 7'd1) begin
					hol = ehdc_pkg::HOL_EASTER_MON;
				end
			end
			if (hol == ehdc_pkg::HOL_NONE && ehdc_pkg::fixed_holiday(mon_s3, day_s3)) begin
				hol = ehdc_pkg::HOL_FIXED;
			end
		end
		wd_d = wd_s3;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (load_s4 && v_s3) begin
			results.weekday      <= wd_d;
			results.weekend      <= (wd_d == 3'd0) || (wd_d == 3'd6);
			results.leap_year    <= leap_s3;
			results.month_length <= len;
			results.easter_month <= (ei > 6'd31) ? 3'd4 : 3'd3;
			results.easter_day   <= (ei > 6'd31) ? 5'(ei - 6'd31) : 5'(ei);
			results.holiday_code <= hol;
		end
	end

	assign results.valid = v_s4;

	// Easter falls between March 22 and April 25.
	a_easter_window: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> ((results.easter_month == 3'd3) && (results.easter_day >= 5'd22)) ||
			((results.easter_month == 3'd4) && (results.easter_day >= 5'd1) &&
			(results.easter_day <= 5'd25)))
		else $error("Easter date outside its window");

	// A holiday is only reported for a real month.
	a_holiday_month: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (results.holiday_code != ehdc_pkg::HOL_NONE)) |->
			(results.month_length != 5'd0))
		else $error("holiday reported for an invalid month");

	// Epact stage remainders stay reduced.
	a_epact_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (epact_s3 < 5'd30) && (nfix_s3 < 3'd7) && (kbc_s3 < 3'd7) && (wd_s3 < 3'd7))
		else $error("epact stage value not reduced");

	// A stalled receiver keeps both back stages occupied.
	a_back_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && v_s4 && !results.ready) |=> (v_s3 && v_s4))
		else $error("back stage dropped content under stall");

endmodule

@@ verif/tb_easter_holiday_date_classifier.sv @@
// Self-checking testbench for easter_holiday_date_classifier: directed dates, then random traffic.
// Depends on ehdc_pkg, ehdc_if and the classifier RTL.
// Expected results come from an in-file predictor, or from the hand-derived values of typed directed rows.

module tb_easter_holiday_date_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS   = 730;
	localparam int QUIET_TAIL     = 120;
	localparam int HOLD_AFTER     = 300;
	localparam int HOLD_CYCLES    = 64;
	localparam int WATCHDOG_LIMIT = 600;

	localparam int unsigned FIXED_MON [9] = '{1, 3, 3, 7, 8, 11, 11, 12, 12};
	localparam int unsigned FIXED_DAY [9] = '{1, 1, 8, 14, 15, 1, 11, 25, 26};

	typedef struct packed {
		logic [2:0] wday;
		logic       weekend;
		logic       leap;
		logic [4:0] mlen;
		logic [2:0] emon;
		logic [4:0] eday;
		logic [2:0] hol;
	} class_res_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  mon;
		logic [13:0] yr;
		logic        typed;
		class_res_t  want;
	} date_row_t;

	// Directed dates; rows with typed set carry a hand-derived result.
	localparam date_row_t DIRECTED [26] = '{
		'{5'd1,  4'd1,  14'd2024,  1'b1,
			'{3'd1, 1'b0, 1'b1, 5'd31, 3'd3, 5'd31, ehdc_pkg::HOL_FIXED}},
		'{5'd5,  4'd0,  14'd2024,  1'b1,
			'{3'd2, 1'b0, 1'b1, 5'd0,  3'd3, 5'd31, ehdc_pkg::HOL_NONE}},
		'{5'd31, 4'd15, 14'd2024,  1'b1,
			'{3'd3, 1'b0, 1'b1, 5'd0,  3'd3, 5'd31, ehdc_pkg::HOL_NONE}},
		'{5'd0,  4'd3,  14'd2024,  1'b1,
			'{3'd4, 1'b0, 1'b1, 5'd31, 3'd3, 5'd31, ehdc_pkg::HOL_NONE}},
		'{5'd31, 4'd3,  14'd2024,  1'b1,
			'{3'd0, 1'b1, 1'b1, 5'd31, 3'd3, 5'd31, ehdc_pkg::HOL_EASTER}},
		'{5'd29, 4'd3,  14'd2024,  1'b0, '0},
		'{5'd1,  4'd4,  14'd2024,  1'b0, '0},
		'{5'd9,  4'd5,  14'd2024,  1'b0, '0},
		'{5'd20, 4'd5,  14'd2024,  1'b0, '0},
		'{5'd19, 4'd4,  14'd1981,  1'b0, '0},
		'{5'd18, 4'd4,  14'd1954,  1'b0, '0},
		'{5'd1,  4'd3,  14'd0,     1'b0, '0},
		'{5'd31, 4'd13, 14'd16383, 1'b0, '0},
		'{5'd31, 4'd14, 14'd0,     1'b0, '0},
		'{5'd15, 4'd10, 14'd1583,  1'b0, '0},
		'{5'd31, 4'd12, 14'd9999,  1'b0, '0},
		'{5'd29, 4'd2,  14'd2000,  1'b0, '0},
		'{5'd29, 4'd2,  14'd1900,  1'b0, '0},
		'{5'd31, 4'd4,  14'd2023,  1'b0, '0},
		'{5'd14, 4'd7,  14'd2024,  1'b0, '0},
		'{5'd15, 4'd8,  14'd2024,  1'b0, '0},
		'{5'd1,  4'd11, 14'd2024,  1'b0, '0},
		'{5'd11, 4'd11, 14'd2024,  1'b0, '0},
		'{5'd25, 4'd12, 14'd2024,  1'b0, '0},
		'{5'd26, 4'd12, 14'd2024,  1'b0, '0},
		'{5'd8,  4'd3,  14'd2024,  1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	ehdc_date_if   date_ch ();
	ehdc_result_if result_ch ();

	easter_holiday_date_classifier dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.dates   (date_ch),
		.results (result_ch)
	);

	class_res_t pending_classes [$];
	int dates_sent     = 0;
	int results_seen   = 0;
	int mismatch_count = 0;
	int stall_cycles   = 0;
	int hol_seen [8]   = '{default: 0};
	bit idle_on        = 1'b1;
	bit rx_hold        = 1'b0;
	bit hold_done      = 1'b0;

	always #5 clk = ~clk;

	// Easter Sunday as a day count from the end of February (April n is 31 + n).
	function automatic int unsigned easter_day_index(input logic [13:0] yr);
		int unsigned y, golden, cent, corr, epact, shift, dd, ee;
		y      = yr;
		golden = y % 19;
		cent   = y / 100;
		corr   = (13 + 8 * cent) / 25;
		epact  = (15 + cent - corr - cent / 4) % 30;
		shift  = (4 + cent - cent / 4) % 7;
		dd     = (19 * golden + epact) % 30;
		ee     = (2 * (y % 4) + 4 * (y % 7) + 6 * dd + shift) % 7;
		if (dd == 29 && ee == 6) begin
			return 50;
		end
		if (dd == 28 && ee == 6 && (11 * epact + 11) % 30 < 19) begin
			return 49;
		end
		return 22 + dd + ee;
	endfunction

	function automatic bit is_fixed_date(input int unsigned m, input int unsigned d);
		bit hit;
		hit = 1'b0;
		for (int i = 0; i < 9; i++) begin
			if (FIXED_MON[i] == m && FIXED_DAY[i] == d) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// Predict the full classification of one date.
	function automatic class_res_t classify_date(input logic [4:0] day, input logic [3:0] mon,
		input logic [13:0] yr);
		class_res_t  r;
		int unsigned d, m, y, early, yy, mm, wd, len, ei, qi;
		d     = day;
		m     = mon;
		y     = yr;
		early = (m <= 2) ? 1 : 0;
		yy    = y + 400 - early;
		mm    = m + 12 * early - 2;
		wd    = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
		r.leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		case (m)
			1, 3, 5, 7, 8, 10, 12: len = 31;
			4, 6, 9, 11:           len = 30;
			2:                     len = r.leap ? 29 : 28;
			default:               len = 0;
		endcase
		ei        = easter_day_index(yr);
		r.wday    = 3'(wd);
		r.weekend = (wd == 0) || (wd == 6);
		r.mlen    = 5'(len);
		r.emon    = (ei > 31) ? 3'd4 : 3'd3;
		r.eday    = 5'((ei > 31) ? ei - 31 : ei);
		r.hol     = ehdc_pkg::HOL_NONE;
		if (len != 0 && d >= 1 && d <= len) begin
			if (m >= 3 && m <= 6) begin
				case (m)
					3:       qi = d;
					4:       qi = 31 + d;
					5:       qi = 61 + d;
					default: qi = 92 + d;
				endcase
				if (qi == ei) begin
					r.hol = ehdc_pkg::HOL_EASTER;
				end else if (qi + 2 == ei) begin
					r.hol = ehdc_pkg::HOL_GOOD_FRI;
				end else if (qi == ei + 39) begin
					r.hol = ehdc_pkg::HOL_ASCENSION;
				end else if (qi == ei + 50) begin
					r.hol = ehdc_pkg::HOL_WHIT_MON;
				end else if (qi == ei + 1) begin
					r.hol = ehdc_pkg::HOL_EASTER_MON;
				end
			end
			if (r.hol == ehdc_pkg::HOL_NONE && is_fixed_date(m, d)) begin
				r.hol = ehdc_pkg::HOL_FIXED;
			end
		end
		return r;
	endfunction

	task automatic log_mismatch(input string what, input class_res_t want, input class_res_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: want wd=%0d we=%0d leap=%0d len=%0d easter=%0d/%0d hol=%0d",
				$realtime, what, want.wday, want.weekend, want.leap, want.mlen, want.emon,
				want.eday, want.hol);
			$display("%0t: %s: got  wd=%0d we=%0d leap=%0d len=%0d easter=%0d/%0d hol=%0d",
				$realtime, what, got.wday, got.weekend, got.leap, got.mlen, got.emon,
				got.eday, got.hol);
		end
	endtask

	// Offer one date, with an occasional idle burst first; hold until accepted.
	task automatic offer_date(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
		input logic typed, input class_res_t typed_res);
		if (idle_on && !rx_hold && $urandom_range(0, 4) == 0) begin
			date_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		date_ch.valid        <= 1'b1;
		date_ch.day_of_month <= d;
		date_ch.month_number <= m;
		date_ch.year_number  <= y;
		do @(posedge clk); while (!date_ch.ready);
		pending_classes.push_back(typed ? typed_res : classify_date(d, m, y));
		dates_sent++;
	endtask

	// Check each result transaction against the oldest prediction.
	always @(posedge clk) begin
		class_res_t got, want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.weekday, result_ch.weekend, result_ch.leap_year,
				result_ch.month_length, result_ch.easter_month, result_ch.easter_day,
				result_ch.holiday_code};
			results_seen++;
			hol_seen[got.hol]++;
			if (pending_classes.size() == 0) begin
				log_mismatch("unexpected result", '0, got);
			end else begin
				want = pending_classes.pop_front();
				if (got.wday !== want.wday || got.weekend !== want.weekend ||
				    got.leap !== want.leap || got.mlen !== want.mlen ||
				    got.emon !== want.emon || got.eday !== want.eday || got.hol !== want.hol) begin
					log_mismatch("wrong result", want, got);
				end
			end
		end
	end

	// Abort when neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((date_ch.valid && date_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d idle cycles", stall_cycles);
				$display("easter_holiday_date_classifier: mismatch");
				$finish;
			end
		end
	end

	// Drive result ready: random stalls, long run stretches, one long hold-off.
	initial begin
		result_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && dates_sent >= HOLD_AFTER) begin
				rx_hold = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				rx_hold   = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Reset, directed dates, random dates, drain, verdict.
	initial begin
		int          k, pick, fix;
		int unsigned ei, qi;
		logic [4:0]  dy;
		logic [3:0]  mo;
		logic [13:0] yr;
		class_res_t  probe;
		arst_n               = 1'b0;
		date_ch.valid        = 1'b0;
		date_ch.day_of_month = '0;
		date_ch.month_number = '0;
		date_ch.year_number  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			offer_date(DIRECTED[i].day, DIRECTED[i].mon, DIRECTED[i].yr, DIRECTED[i].typed,
				DIRECTED[i].want);
		end

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS - QUIET_TAIL) begin
				idle_on = 1'b0;
			end
			pick = $urandom_range(0, 99);
			yr   = 14'($urandom_range(1583, 9999));
			if (pick < 15) begin
				// raw field values, out-of-range ones included
				dy = 5'($urandom_range(0, 31));
				mo = 4'($urandom_range(0, 15));
				yr = 14'($urandom_range(0, 16383));
			end else if (pick < 50) begin
				// dates on and around the Easter-based holidays
				ei = easter_day_index(yr);
				case ($urandom_range(0, 5))
					0:       qi = ei - 2;
					1:       qi = ei;
					2:       qi = ei + 1;
					3:       qi = ei + 39;
					4:       qi = ei + 50;
					default: qi = ei - 3 + $urandom_range(0, 57);
				endcase
				if (qi <= 31) begin
					mo = 4'd3;
					dy = 5'(qi);
				end else if (qi <= 61) begin
					mo = 4'd4;
					dy = 5'(qi - 31);
				end else if (qi <= 92) begin
					mo = 4'd5;
					dy = 5'(qi - 61);
				end else begin
					mo = 4'd6;
					dy = 5'(qi - 92);
				end
			end else if (pick < 60) begin
				fix = $urandom_range(0, 8);
				mo  = 4'(FIXED_MON[fix]);
				dy  = 5'(FIXED_DAY[fix]);
			end else begin
				// well-formed date anywhere in the year
				if ($urandom_range(0, 9) == 0) begin
					yr = 14'($urandom_range(0, 16383));
				end
				mo    = 4'($urandom_range(1, 12));
				probe = classify_date(5'd1, mo, yr);
				dy    = 5'($urandom_range(1, probe.mlen));
			end
			offer_date(dy, mo, yr, 1'b0, '0);
		end
		date_ch.valid <= 1'b0;

		while (pending_classes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d dates (%0d directed), checked %0d results, %0d mismatches",
			dates_sent, $size(DIRECTED), results_seen, mismatch_count);
		$display("holidays: none %0d easter %0d good-fri %0d ascension %0d",
			hol_seen[0], hol_seen[1], hol_seen[2], hol_seen[3]);
		$display("          whit %0d easter-mon %0d fixed %0d",
			hol_seen[4], hol_seen[5], hol_seen[6]);
		if (mismatch_count == 0) begin
			$display("easter_holiday_date_classifier: match");
		end else begin
			$display("easter_holiday_date_classifier: mismatch");
		end
		$finish;
	end

endmodule
